// ===== rtl/hlsc_pkg.sv =====
// hlsc_pkg: shared types and constants for the heat limited shot controller
// no dependencies; used by the channel interfaces, the divider and the top level

package hlsc_pkg;

  // payload widths
  localparam int HEAT_W     = 13;
  localparam int CFG12_W    = 12;
  localparam int COUNT_W    = 16;
  localparam int TOL_W      = 15;
  localparam int ERR_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int WAIT_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // divider geometry: dividend is limit minus heat, at most 8189
  localparam int DIV_W     = 13;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // cooling happens on every tenth update tick
  localparam logic [WAIT_W-1:0] COOL_DIVIDE = 4'd9;
  localparam logic [CFG12_W-1:0] ALLOW_MAX  = 12'hFFF;

  // register reset values
  localparam logic [CFG12_W-1:0] HEAT_LIMIT_RST    = 12'd80;
  localparam logic [CFG12_W-1:0] HEAT_PER_SHOT_RST = 12'd100;
  localparam logic [CFG12_W-1:0] COOLING_STEP_RST  = 12'd2;
  localparam logic [COUNT_W-1:0] BUSY_TIMEOUT_RST  = 16'd500;
  localparam logic [COUNT_W-1:0] ERROR_HOLD_RST    = 16'd250;
  localparam logic [TOL_W-1:0]   SETTLE_TOL_RST    = 15'd10;

  // status codes on the result word
  localparam logic [STATUS_W-1:0] STATUS_READY = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAT_LIMIT    = 3'd0,
    REG_HEAT_PER_SHOT = 3'd1,
    REG_COOLING_STEP  = 3'd2,
    REG_BUSY_TIMEOUT  = 3'd3,
    REG_ERROR_HOLD    = 3'd4,
    REG_SETTLE_TOL    = 3'd5
  } cfg_reg_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [CFG12_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/hlsc_if.sv =====
// hlsc_if: valid/ready channels for tick words, result words and register writes
// depends on hlsc_pkg for the payload widths

interface hlsc_tick_if;
  import hlsc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    shoot_request;
  logic                    cool_tick;
  logic signed [ERR_W-1:0] angle_error;
  logic signed [ERR_W-1:0] speed_error;
  modport source (output valid, shoot_request, cool_tick, angle_error, speed_error,
                  input ready);
  modport sink (input valid, shoot_request, cool_tick, angle_error, speed_error,
                output ready);
endinterface

interface hlsc_result_if;
  import hlsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     fire;
  logic signed [HEAT_W-1:0] heat_now;
  logic [CFG12_W-1:0]       shots_allowed;
  modport source (output valid, status, fire, heat_now, shots_allowed, input ready);
  modport sink (input valid, status, fire, heat_now, shots_allowed, output ready);
endinterface

interface hlsc_cfg_if;
  import hlsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/hlsc_divider.sv =====
// hlsc_divider: restoring divider, one quotient bit per cycle
// depends on hlsc_pkg for the request and response structs

module hlsc_divider (
  input  logic              clk,
  input  logic              rst,
  input  hlsc_pkg::div_req_t req,
  output hlsc_pkg::div_rsp_t rsp
);
  import hlsc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CFG12_W-1:0]   rem;
  logic [DIV_W-1:0]     quo;
  logic [CFG12_W-1:0]   divisor_q;
  logic [DIV_W-1:0]     trial;
  logic [DIV_W-1:0]     diff;
  logic                 fits;

  // remainder stays below the divisor, so it fits in 12 bits
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem       <= '0;
      quo       <= req.dividend;
      divisor_q <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[CFG12_W-1:0] : trial[CFG12_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/heat_limited_shot_controller.sv =====
// heat_limited_shot_controller: per-tick heat bookkeeping and single-shot state machine
// an accepted tick word passes S_STEP, then S_DIV while an allowance division runs, then
//   S_PUT, where the result word is loaded once the result register is free
// a new tick word is taken only in S_IDLE, after the previous result word is loaded
// rst (synchronous, active high) restores register defaults, ready state, zero heat
// depends on hlsc_pkg, hlsc_if and hlsc_divider

module heat_limited_shot_controller (
  input  logic                 clk,
  input  logic                 rst,
  hlsc_tick_if.sink            tick,
  hlsc_result_if.source        result,
  hlsc_cfg_if.sink             cfg
);
  import hlsc_pkg::*;

  // sequencer: take word, step, optional division, hand off result
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUT  = 4'b1000
  } seq_state_t;

  // shot state machine
  typedef enum logic [2:0] {
    SHOT_READY = 3'b001,
    SHOT_BUSY  = 3'b010,
    SHOT_ERROR = 3'b100
  } shot_state_t;

  seq_state_t  seq, seq_next;
  shot_state_t shot_state;

  // configuration registers
  logic [CFG12_W-1:0] heat_limit;
  logic [CFG12_W-1:0] heat_per_shot;
  logic [CFG12_W-1:0] cooling_step;
  logic [COUNT_W-1:0] busy_timeout;
  logic [COUNT_W-1:0] error_hold;
  logic [TOL_W-1:0]   settle_tolerance;

  // block state
  logic signed [HEAT_W-1:0] heat_level;
  logic [WAIT_W-1:0]        cooling_wait;
  logic [CFG12_W-1:0]       allowance;
  logic [COUNT_W-1:0]       busy_ticks;
  logic [COUNT_W-1:0]       error_ticks;

  // captured tick word
  logic                    req_q;
  logic                    cool_q;
  logic signed [ERR_W-1:0] ang_q;
  logic signed [ERR_W-1:0] spd_q;
  logic                    fire_q;

  logic accept;
  logic put_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------------------------------------------------------------------
  // register writes; the port never stalls
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_limit       <= HEAT_LIMIT_RST;
      heat_per_shot    <= HEAT_PER_SHOT_RST;
      cooling_step     <= COOLING_STEP_RST;
      busy_timeout     <= BUSY_TIMEOUT_RST;
      error_hold       <= ERROR_HOLD_RST;
      settle_tolerance <= SETTLE_TOL_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_HEAT_LIMIT:    heat_limit       <= cfg.data[CFG12_W-1:0];
        REG_HEAT_PER_SHOT: heat_per_shot    <= cfg.data[CFG12_W-1:0];
        REG_COOLING_STEP:  cooling_step     <= cfg.data[CFG12_W-1:0];
        REG_BUSY_TIMEOUT:  busy_timeout     <= cfg.data;
        REG_ERROR_HOLD:    error_hold       <= cfg.data;
        REG_SETTLE_TOL:    settle_tolerance <= cfg.data[TOL_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign tick.ready = (seq == S_IDLE);
  assign accept     = tick.valid && tick.ready;
  // result register frees up when empty or when its word is taken
  assign put_load   = (seq == S_PUT) && (!result.valid || result.ready);

  // ---------------------------------------------------------------------------
  // cooling step, done on the accept edge (heat update runs before the shot logic)
  // ---------------------------------------------------------------------------
  logic [WAIT_W-1:0]        wait_inc;
  logic signed [HEAT_W-1:0] heat_cooled;

  assign wait_inc    = cooling_wait + 1'b1;
  // heat above zero sheds one step and may dip below zero; otherwise it clamps to zero
  assign heat_cooled = (heat_level > 0) ? heat_level - $signed({1'b0, cooling_step})
                                        : '0;

  // ---------------------------------------------------------------------------
  // shot step terms, evaluated in S_STEP on the cooled heat
  // ---------------------------------------------------------------------------
  logic signed [HEAT_W:0]  heat_after_shot;
  logic                    shot_fits;
  logic                    over_limit;
  logic [DIV_W-1:0]        headroom;
  logic [ERR_W:0]          ang_mag;
  logic [ERR_W:0]          spd_mag;
  logic                    settled;
  logic [COUNT_W-1:0]      busy_inc;
  logic [COUNT_W-1:0]      error_inc;

  assign heat_after_shot = {heat_level[HEAT_W-1], heat_level} + $signed({2'b0, heat_per_shot});
  assign shot_fits       = heat_after_shot < $signed({2'b0, heat_limit});
  assign over_limit      = heat_level > $signed({1'b0, heat_limit});
  // only used when heat is within the limit, so the difference is non-negative
  assign headroom        = {1'b0, heat_limit} - heat_level;

  // magnitudes on 17 bits so that the most negative error stays unsettled
  assign ang_mag = ang_q[ERR_W-1] ? (ERR_W+1)'(-{ang_q[ERR_W-1], ang_q}) : {1'b0, ang_q};
  assign spd_mag = spd_q[ERR_W-1] ? (ERR_W+1)'(-{spd_q[ERR_W-1], spd_q}) : {1'b0, spd_q};
  assign settled = (ang_mag < {2'b0, settle_tolerance}) &&
                   (spd_mag < {2'b0, settle_tolerance});

  assign busy_inc  = busy_ticks + 1'b1;
  assign error_inc = error_ticks + 1'b1;

  // division runs only on update ticks with heat within the limit and a nonzero divisor
  assign div_req.start    = (seq == S_STEP) && cool_q && !over_limit &&
                            (heat_per_shot != '0);
  assign div_req.dividend = headroom;
  assign div_req.divisor  = heat_per_shot;

  hlsc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_next = seq;
    unique case (seq)
      S_IDLE: if (accept) seq_next = S_STEP;
      S_STEP: seq_next = div_req.start ? S_DIV : S_PUT;
      S_DIV:  if (div_rsp.done) seq_next = S_PUT;
      S_PUT:  if (put_load) seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) seq <= S_IDLE;
    else     seq <= seq_next;
  end

  // captured word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= tick.shoot_request;
      cool_q <= tick.cool_tick;
      ang_q  <= tick.angle_error;
      spd_q  <= tick.speed_error;
    end
  end

  // ---------------------------------------------------------------------------
  // heat, allowance and shot state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      heat_level   <= '0;
      cooling_wait <= '0;
      allowance    <= '0;
      shot_state   <= SHOT_READY;
      busy_ticks   <= '0;
      error_ticks  <= '0;
      fire_q       <= 1'b0;
    end else begin
      // cooling counter and cooling step
      if (accept && tick.cool_tick) begin
        if (wait_inc > COOL_DIVIDE) begin
          cooling_wait <= '0;
          heat_level   <= heat_cooled;
        end else begin
          cooling_wait <= wait_inc;
        end
      end

      if (seq == S_STEP) begin
        // allowance on update ticks; the divider path fills it in later
        if (cool_q) begin
          if (over_limit) allowance <= '0;
          else if (heat_per_shot == '0) allowance <= ALLOW_MAX;
        end

        fire_q <= 1'b0;
        unique case (shot_state)
          SHOT_BUSY: begin
            error_ticks <= '0;
            if (busy_inc < busy_timeout) begin
              busy_ticks <= busy_inc;
              if (settled) shot_state <= SHOT_READY;
            end else begin
              // feeder stuck
              busy_ticks <= '0;
              shot_state <= SHOT_ERROR;
            end
          end
          SHOT_ERROR: begin
            busy_ticks <= '0;
            if (error_inc >= error_hold) begin
              error_ticks <= '0;
              shot_state  <= SHOT_READY;
            end else begin
              error_ticks <= error_inc;
            end
          end
          default: begin
            busy_ticks  <= '0;
            error_ticks <= '0;
            if (req_q && shot_fits) begin
              heat_level <= heat_after_shot[HEAT_W-1:0];
              shot_state <= SHOT_BUSY;
              fire_q     <= 1'b1;
            end
          end
        endcase
      end

      // quotient saturates to the 12 bit allowance
      if ((seq == S_DIV) && div_rsp.done) begin
        allowance <= div_rsp.quotient[DIV_W-1] ? ALLOW_MAX
                                               : div_rsp.quotient[CFG12_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [STATUS_W-1:0] status_code;

  always_comb begin
    unique case (shot_state)
      SHOT_BUSY:  status_code = STATUS_BUSY;
      SHOT_ERROR: status_code = STATUS_ERROR;
      default:    status_code = STATUS_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (put_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_load) begin
      result.status        <= status_code;
      result.fire          <= fire_q;
      result.heat_now      <= heat_level;
      result.shots_allowed <= allowance;
    end
  end

`ifndef SYNTH
  // a shot that fires always leaves the machine busy
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.fire |-> result.status == STATUS_BUSY)
    else $error("fire reported outside busy status");

  // the divider answers only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> seq == S_DIV)
    else $error("divider done outside division wait");

  // heat never drops below -4095
  a_heat_range: assert property (@(posedge clk) disable iff (rst)
    heat_level >= -13'sd4095)
    else $error("heat level out of range");
`endif

endmodule

// ===== tb/hlsc_shot_checker.sv =====
// hlsc_shot_checker: passive monitor and scoreboard for the heat limited shot controller
// watches the tick, result and register channels, predicts each result word and compares
// depends on hlsc_pkg and hlsc_if

module hlsc_shot_checker (
  input  logic   clk,
  input  logic   rst,
  hlsc_tick_if   tick,
  hlsc_result_if result,
  hlsc_cfg_if    cfg,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hlsc_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                fire;
    logic [HEAT_W-1:0]   heat_now;
    logic [CFG12_W-1:0]  shots_allowed;
  } shot_word_t;

  shot_word_t expected_words[$];

  // register shadow
  logic [CFG12_W-1:0] limit_reg, per_shot_reg, cool_step_reg;
  logic [COUNT_W-1:0] timeout_reg, hold_reg;
  logic [TOL_W-1:0]   tol_reg;

  // controller shadow
  logic [STATUS_W-1:0] shot_mode;
  logic [COUNT_W-1:0]  busy_count, error_count;
  logic [WAIT_W-1:0]   cool_count;
  logic [CFG12_W-1:0]  allowance;
  int                  heat;
  int                  words_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    words_seen = 0;
  end

  function automatic int magnitude(logic signed [ERR_W-1:0] v);
    int w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // one tick: heat update first, then the shot state machine
  function automatic shot_word_t advance_controller(logic req, logic cool,
      logic signed [ERR_W-1:0] ang, logic signed [ERR_W-1:0] spd);
    shot_word_t w;
    int quot;
    w.fire = 1'b0;
    if (cool) begin
      cool_count = cool_count + 1'b1;
      if (cool_count > COOL_DIVIDE) begin
        cool_count = '0;
        if (heat > 0) heat = heat - int'(cool_step_reg);
        else heat = 0;
      end
      if (heat > int'(limit_reg)) allowance = '0;
      else if (per_shot_reg == '0) allowance = ALLOW_MAX;
      else begin
        quot = (int'(limit_reg) - heat) / int'(per_shot_reg);
        allowance = (quot > int'(ALLOW_MAX)) ? ALLOW_MAX : quot[CFG12_W-1:0];
      end
    end
    case (shot_mode)
      STATUS_BUSY: begin
        busy_count  = busy_count + 1'b1;
        error_count = '0;
        if (busy_count < timeout_reg) begin
          if (magnitude(ang) < int'(tol_reg) && magnitude(spd) < int'(tol_reg))
            shot_mode = STATUS_READY;
        end else begin
          busy_count = '0;
          shot_mode  = STATUS_ERROR;
        end
      end
      STATUS_ERROR: begin
        busy_count  = '0;
        error_count = error_count + 1'b1;
        if (error_count >= hold_reg) begin
          error_count = '0;
          shot_mode   = STATUS_READY;
        end
      end
      default: begin
        busy_count  = '0;
        error_count = '0;
        if (req && heat + int'(per_shot_reg) < int'(limit_reg)) begin
          heat      = heat + int'(per_shot_reg);
          shot_mode = STATUS_BUSY;
          w.fire    = 1'b1;
        end
      end
    endcase
    w.status        = shot_mode;
    w.heat_now      = heat[HEAT_W-1:0];
    w.shots_allowed = allowance;
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("result word %0d: %s, got %0d, wanted %0d", words_seen, what, got, want);
    fail_count++;
  endtask

  task automatic check_word();
    shot_word_t w;
    words_seen++;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing pending", 1, 0);
    end else begin
      w = expected_words.pop_front();
      if (result.status !== w.status)
        report_mismatch("status", int'(result.status), int'(w.status));
      if (result.fire !== w.fire)
        report_mismatch("fire", int'(result.fire), int'(w.fire));
      if (result.heat_now !== w.heat_now)
        report_mismatch("heat_now", int'($signed(result.heat_now)),
                        int'($signed(w.heat_now)));
      if (result.shots_allowed !== w.shots_allowed)
        report_mismatch("shots_allowed", int'(result.shots_allowed),
                        int'(w.shots_allowed));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit_reg     = HEAT_LIMIT_RST;
      per_shot_reg  = HEAT_PER_SHOT_RST;
      cool_step_reg = COOLING_STEP_RST;
      timeout_reg   = BUSY_TIMEOUT_RST;
      hold_reg      = ERROR_HOLD_RST;
      tol_reg       = SETTLE_TOL_RST;
      shot_mode     = STATUS_READY;
      busy_count    = '0;
      error_count   = '0;
      cool_count    = '0;
      allowance     = '0;
      heat          = 0;
      expected_words.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HEAT_LIMIT:    limit_reg     = cfg.data[CFG12_W-1:0];
          REG_HEAT_PER_SHOT: per_shot_reg  = cfg.data[CFG12_W-1:0];
          REG_COOLING_STEP:  cool_step_reg = cfg.data[CFG12_W-1:0];
          REG_BUSY_TIMEOUT:  timeout_reg   = cfg.data[COUNT_W-1:0];
          REG_ERROR_HOLD:    hold_reg      = cfg.data[COUNT_W-1:0];
          REG_SETTLE_TOL:    tol_reg       = cfg.data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) check_word();
      if (tick.valid && tick.ready)
        expected_words.push_back(advance_controller(tick.shoot_request, tick.cool_tick,
                                                    tick.angle_error, tick.speed_error));
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/tb_heat_limited_shot_controller.sv =====
// tb_heat_limited_shot_controller: stimulus and verdict for the heat limited shot controller
// drives tick words and register writes, stalls the result side, checking sits in
// hlsc_shot_checker; depends on hlsc_pkg, hlsc_if, the controller and the checker

module tb_heat_limited_shot_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import hlsc_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  // margin before a register write once every predicted word has come back
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_TICKS   = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   words_pending;
  int   cycle_count  = 0;
  int   tol_now      = SETTLE_TOL_RST;
  bit   sender_calm  = 1'b0;
  bit   quiet_errors = 1'b0;

  hlsc_tick_if   tick_ch ();
  hlsc_result_if result_ch ();
  hlsc_cfg_if    cfg_ch ();

  heat_limited_shot_controller DUT (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  hlsc_shot_checker shot_checker (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (words_pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // motor error: quiet stretches sit inside the tolerance so shots complete,
  // otherwise a mix of near-threshold, tiny, extreme and fully random values
  function automatic logic [ERR_W-1:0] pick_error();
    int r;
    r = $urandom_range(0, 9);
    if (quiet_errors && r < 7)
      return ERR_W'(int'($urandom_range(0, 2 * tol_now)) - tol_now);
    if (r < 3) return ERR_W'(int'($urandom_range(0, 2 * tol_now + 2)) - tol_now - 1);
    if (r < 5) return ERR_W'(int'($urandom_range(0, 32)) - 16);
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h8001;
        default: return '0;
      endcase
    end
    return ERR_W'($urandom());
  endfunction

  // one tick word; leaves valid high so back-to-back words need no extra step
  task automatic send_tick(bit req, bit cool, logic [ERR_W-1:0] ang,
                           logic [ERR_W-1:0] spd);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.shoot_request <= req;
    tick_ch.cool_tick     <= cool;
    tick_ch.angle_error   <= ang;
    tick_ch.speed_error   <= spd;
    tick_ch.valid         <= 1'b1;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // register write word; caller lowers valid after the last one
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every predicted word has come back
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(int lim, int per_shot, int cool, int tmo, int hold, int tol);
    drain_results();
    write_reg(REG_HEAT_LIMIT,    CFG_DATA_W'(lim));
    write_reg(REG_HEAT_PER_SHOT, CFG_DATA_W'(per_shot));
    write_reg(REG_COOLING_STEP,  CFG_DATA_W'(cool));
    write_reg(REG_BUSY_TIMEOUT,  CFG_DATA_W'(tmo));
    write_reg(REG_ERROR_HOLD,    CFG_DATA_W'(hold));
    write_reg(REG_SETTLE_TOL,    CFG_DATA_W'(tol));
    cfg_ch.valid <= 1'b0;
    tol_now = tol & ((1 << TOL_W) - 1);
  endtask

  task automatic random_ticks(int count);
    for (int i = 0; i < count; i++) begin
      // switch sender pacing and error character every few dozen words
      if (i % 40 == 0) begin
        sender_calm  = ($urandom_range(0, 4) == 0);
        quiet_errors = $urandom_range(0, 1);
      end
      // occasional full pause until the pipeline is empty
      if ($urandom_range(0, 149) == 0) drain_results();
      send_tick($urandom_range(0, 1), ($urandom_range(0, 9) < 6), pick_error(), pick_error());
    end
  endtask

  // result side: ready with random stalls, sometimes a long stall-free stretch
  initial begin
    int hold_high;
    int gap;
    result_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      result_ch.ready <= 1'b1;
      hold_high = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12);
      repeat (hold_high) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    tick_ch.valid         = 1'b0;
    tick_ch.shoot_request = 1'b0;
    tick_ch.cool_tick     = 1'b0;
    tick_ch.angle_error   = '0;
    tick_ch.speed_error   = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_HEAT_LIMIT;
    cfg_ch.data           = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: a shot never fits under the default ceiling
    send_tick(1'b1, 1'b1, 16'h8000, 16'h7FFF);
    send_tick(1'b0, 1'b0, 16'h7FFF, 16'h8000);
    send_tick(1'b1, 1'b0, '0, '0);

    // widest ceiling, unit heat per shot, so the allowance reaches its 12 bit maximum
    set_config(4095, 1, 4095, 3, 2, 32767);
    send_tick(1'b1, 1'b1, '0, '0);
    // most negative error never counts as settled even at the widest tolerance
    send_tick(1'b0, 1'b0, 16'h8000, 16'h8000);
    // magnitude equal to the tolerance is not settled either
    send_tick(1'b0, 1'b0, 16'h7FFF, 16'h7FFF);
    // third busy tick hits the timeout
    send_tick(1'b0, 1'b0, 16'h7FFF, 16'h8001);
    // request ignored while in error, then hold expires
    send_tick(1'b1, 1'b0, 16'h8001, 16'h7FFE);
    send_tick(1'b1, 1'b0, '0, '0);
    // fire and settle right away
    send_tick(1'b1, 1'b0, 16'h7FFE, 16'h8002);
    send_tick(1'b0, 1'b0, 16'h7FFE, 16'h8002);
    // nine update ticks: cooling drives the heat well below zero
    repeat (9) send_tick(1'b0, 1'b1, '0, '0);

    // busy counter already past a lowered timeout errors on its next tick
    set_config(4095, 1, 4095, 40, 2, 32767);
    send_tick(1'b1, 1'b0, '0, '0);
    repeat (4) send_tick(1'b0, 1'b0, 16'h8000, '0);
    drain_results();
    write_reg(REG_BUSY_TIMEOUT, 16'd2);
    cfg_ch.valid <= 1'b0;
    send_tick(1'b0, 1'b0, 16'h8000, 16'h8000);
    send_tick(1'b0, 1'b1, '0, '0);

    // random phases over a spread of register settings
    set_config(1000, 60, 40, 25, 12, 200);
    random_ticks(PHASE_TICKS);
    // saturated allowance and deep negative heat
    set_config(4095, 1, 4095, 8, 3, 500);
    random_ticks(PHASE_TICKS);
    // zero divisor, zero timeout and zero hold
    set_config(500, 0, 7, 0, 0, 32767);
    random_ticks(PHASE_TICKS);
    // zero ceiling, zero cooling, zero tolerance
    set_config(0, 1, 0, 1, 1, 0);
    random_ticks(PHASE_TICKS);
    // every register at its top value
    set_config(4095, 4095, 4095, 65535, 65535, 32767);
    random_ticks(PHASE_TICKS);
    set_config(2000, 150, 300, 30, 20, 1000);
    random_ticks(PHASE_TICKS);
    // random settings, upper data bits set to check the register widths
    repeat (2) begin
      set_config($urandom_range(0, 65535),
                 ($urandom_range(0, 15) << 12) | $urandom_range(0, 300),
                 $urandom_range(0, 65535),
                 $urandom_range(0, 60),
                 $urandom_range(0, 40),
                 ($urandom_range(0, 1) << 15) | $urandom_range(0, 3000));
      random_ticks(PHASE_TICKS);
    end

    drain_results();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
